// ===== sv/sdcm_pkg.sv =====
// Shared types, widths and codes for the slotted duty-cycle meter.
package sdcm_pkg;

	localparam int MAX_SLOTS  = 60;
	localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
	localparam int NOW_W      = 32;
	localparam int DUR_W      = 22;
	localparam int CNT_W      = 6;
	localparam int DUTY_W     = 16;
	localparam int FULL_W     = DUR_W + CNT_W;
	// 60 slots of up to 2^32-1 ms each
	localparam int SUM_W      = 38;
	// sum * 25600 needs 15 more bits
	localparam int DVD_W      = SUM_W + 15;
	localparam int DIV_W      = 32;
	localparam int LEN_W      = 6;
	localparam int ENTRY_W    = 2 * NOW_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DUR_W;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_DURATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 1'd1;

	localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(60);

	// iteration counts: 32-bit dividend, or the scaled sum
	localparam logic [LEN_W-1:0] LEN_WORD = LEN_W'(NOW_W);
	localparam logic [LEN_W-1:0] LEN_DUTY = LEN_W'(DVD_W);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_END   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EPOCH_GO,
		ST_EPOCH_WAIT,
		ST_MOD_GO,
		ST_MOD_WAIT,
		ST_END_RD,
		ST_END_WR,
		ST_SUM,
		ST_SUM_LAST,
		ST_DUTY_GO,
		ST_DUTY_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] len;
		logic [DVD_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== sv/sdcm_if.sv =====
// Handshake channels of the duty-cycle meter: items, results and register writes.
interface sdcm_req_if import sdcm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       operation;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, operation, now_ms, input ready);
	modport sink (input valid, operation, now_ms, output ready);
endinterface

interface sdcm_rsp_if import sdcm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_percent_q8;
	logic [NOW_W-1:0]  tx_elapsed_ms;
	logic              tx_busy;

	modport source (output valid, duty_percent_q8, tx_elapsed_ms, tx_busy, input ready);
	modport sink (input valid, duty_percent_q8, tx_elapsed_ms, tx_busy, output ready);
endinterface

interface sdcm_cfg_if import sdcm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/slotted_duty_cycle_meter.sv =====
// Top level: sliding-window transmit duty-cycle meter with a shared iterative divider.
// Start, unused operations and an end while idle: the result is registered from the finish state.
// End while active: two 32-step divisions, then a slot read-modify-write.
// Query: 32-step epoch division, one slot read per cycle, then a 53-step duty division
// (a query at time zero skips these); one item at a time, ready only when idle.
// Async reset clears slot valid bits, transmit state and registers to defaults.
module slotted_duty_cycle_meter import sdcm_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	sdcm_req_if.sink   req,
	sdcm_rsp_if.source rsp,
	sdcm_cfg_if.sink   cfg
);
	state_t state_q, state_d;

	logic [DUR_W-1:0]      dur_q;
	logic [CNT_W-1:0]      cnt_cfg_q;
	logic [DUR_W-1:0]      dur_eff;
	logic [CNT_W-1:0]      n_eff;
	logic [FULL_W-1:0]     full_len;

	op_t                   op_q;
	logic [NOW_W-1:0]      now_q;
	logic [NOW_W-1:0]      window_q;
	logic [NOW_W-1:0]      epoch_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic [SLOT_IDX_W-1:0] rd_idx_q;
	logic [SLOT_IDX_W-1:0] idx_s1;
	logic                  pend_s1;
	logic [SUM_W-1:0]      sum_q;
	logic [DUTY_W-1:0]     duty_q;
	logic [NOW_W-1:0]      start_q;
	logic                  tx_active_q;
	logic [MAX_SLOTS-1:0]  slot_valid_q;

	logic                  out_valid_q;
	logic [DUTY_W-1:0]     out_duty_q;
	logic [NOW_W-1:0]      out_elapsed_q;
	logic                  out_busy_q;

	div_req_t              div_req;
	div_rsp_t              div_rsp;

	logic                  ram_we;
	logic [SLOT_IDX_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic [NOW_W-1:0]      rd_epoch;
	logic [NOW_W-1:0]      rd_time;
	logic [NOW_W-1:0]      elapsed;
	logic [NOW_W:0]        slot_add;
	logic [NOW_W-1:0]      slot_base;
	logic [DVD_W-1:0]      scaled;
	logic                  accept;
	logic                  out_free;
	logic                  sum_hit;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// effective register values
	assign dur_eff  = (dur_q == '0) ? DUR_W'(1) : dur_q;
	assign n_eff    = (cnt_cfg_q == '0) ? CNT_W'(1) :
		(cnt_cfg_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cnt_cfg_q;
	assign full_len = FULL_W'(dur_eff) * FULL_W'(n_eff);

	// configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q     <= DUR_RESET;
			cnt_cfg_q <= CNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_SLOT_DURATION: dur_q <= cfg.data[DUR_W-1:0];
				CFG_SLOT_COUNT:    cnt_cfg_q <= cfg.data[CNT_W-1:0];
				default:           ;
			endcase
		end
	end

	sdcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sdcm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_epoch = ram_rdata[ENTRY_W-1:NOW_W];
	assign rd_time  = ram_rdata[NOW_W-1:0];
	assign elapsed  = now_q - start_q;

	// end of transmit: stale slot restarts from zero, sum saturates
	assign slot_base = (slot_valid_q[idx_q] && rd_epoch == epoch_q) ? rd_time : '0;
	assign slot_add  = {1'b0, slot_base} + {1'b0, elapsed};
	assign ram_wdata = {epoch_q, slot_add[NOW_W] ? {NOW_W{1'b1}} : slot_add[NOW_W-1:0]};

	// sum * 25600 = sum * (2^14 + 2^13 + 2^10)
	assign scaled = (DVD_W'(sum_q) << 14) + (DVD_W'(sum_q) << 13) + (DVD_W'(sum_q) << 10);

	// slot counts when valid and younger than the slot count
	assign sum_hit = pend_s1 && slot_valid_q[idx_s1] &&
		((epoch_q - rd_epoch) < NOW_W'(n_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		req.ready        = 1'b0;
		ram_we           = 1'b0;
		ram_raddr        = rd_idx_q;
		div_req.start    = 1'b0;
		div_req.len      = LEN_WORD;
		div_req.dividend = {now_q, (DVD_W - NOW_W)'(0)};
		div_req.divisor  = DIV_W'(dur_eff);
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (accept) begin
					case (op_t'(req.operation))
						OP_END:   state_d = tx_active_q ? ST_EPOCH_GO : ST_FINISH;
						OP_QUERY: state_d = (req.now_ms == '0) ? ST_FINISH : ST_EPOCH_GO;
						default:  state_d = ST_FINISH;
					endcase
				end
			end
			ST_EPOCH_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_EPOCH_WAIT;
			end
			ST_EPOCH_WAIT: begin
				if (div_rsp.done) begin
					state_d = (op_q == OP_END) ? ST_MOD_GO : ST_SUM;
				end
			end
			ST_MOD_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {epoch_q, (DVD_W - NOW_W)'(0)};
				div_req.divisor  = DIV_W'(n_eff);
				state_d          = ST_MOD_WAIT;
			end
			ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_END_RD;
				end
			end
			ST_END_RD: begin
				ram_raddr = idx_q;
				state_d   = ST_END_WR;
			end
			ST_END_WR: begin
				ram_we  = 1'b1;
				state_d = ST_FINISH;
			end
			ST_SUM: begin
				if (rd_idx_q == SLOT_IDX_W'(n_eff - CNT_W'(1))) begin
					state_d = ST_SUM_LAST;
				end
			end
			ST_SUM_LAST: begin
				state_d = ST_DUTY_GO;
			end
			ST_DUTY_GO: begin
				div_req.start    = 1'b1;
				div_req.len      = LEN_DUTY;
				div_req.dividend = scaled;
				div_req.divisor  = window_q;
				state_d          = ST_DUTY_WAIT;
			end
			ST_DUTY_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// transmit state and slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_active_q  <= 1'b0;
			start_q      <= '0;
			slot_valid_q <= '0;
			pend_s1      <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SUM);
			if (accept && op_t'(req.operation) == OP_START) begin
				tx_active_q <= 1'b1;
				start_q     <= req.now_ms;
			end
			if (ram_we) begin
				slot_valid_q[idx_q] <= 1'b1;
				tx_active_q         <= 1'b0;
				start_q             <= '0;
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(req.operation);
			now_q    <= req.now_ms;
			window_q <= (req.now_ms < NOW_W'(full_len)) ? req.now_ms : NOW_W'(full_len);
			duty_q   <= '0;
			rd_idx_q <= '0;
			sum_q    <= '0;
		end
		if (state_q == ST_EPOCH_WAIT && div_rsp.done) begin
			epoch_q <= div_rsp.quotient[NOW_W-1:0];
		end
		if (state_q == ST_MOD_WAIT && div_rsp.done) begin
			idx_q <= div_rsp.remainder[SLOT_IDX_W-1:0];
		end
		if (state_q == ST_SUM) begin
			rd_idx_q <= rd_idx_q + SLOT_IDX_W'(1);
		end
		idx_s1 <= rd_idx_q;
		if (sum_hit) begin
			sum_q <= sum_q + SUM_W'(rd_time);
		end
		if (state_q == ST_DUTY_WAIT && div_rsp.done) begin
			duty_q <= (div_rsp.quotient[DVD_W-1:DUTY_W] != '0) ? {DUTY_W{1'b1}}
				: div_rsp.quotient[DUTY_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_duty_q    <= duty_q;
			out_elapsed_q <= tx_active_q ? elapsed : '0;
			out_busy_q    <= tx_active_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.duty_percent_q8 = out_duty_q;
	assign rsp.tx_elapsed_ms   = out_elapsed_q;
	assign rsp.tx_busy         = out_busy_q;

	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_IDLE |-> !div_rsp.busy)
		else $error("divider still busy while taking a new item");
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q != ST_IDLE)
		else $error("accepted item produced no work");
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> tx_active_q)
		else $error("slot updated without an active transmission");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_END_RD |-> CNT_W'(idx_q) < n_eff)
		else $error("slot index outside the window");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUTY_GO |-> window_q != '0)
		else $error("duty division by an empty window");
endmodule

// ===== sv/sdcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sdcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/sdcm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module sdcm_div import sdcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] divisor_q;
	logic [LEN_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - LEN_W'(1);
				if (cnt_q == LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
			quo_q     <= '0;
			rem_q     <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still iterating");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> busy_q)
		else $error("divider did not begin after start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != '0)
		else $error("divider busy with empty iteration count");
endmodule
